/* rtl/pua_pkg.sv */
// ----------------------------------------------------------------------------
// pua_pkg - shared types, constants and trig table for the polar unwarp
// address generator: request/result structs, register indexes, and the
// quarter-wave sine table in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

package pua_pkg;

  localparam int PAN_WIDTH  = 360;
  localparam int PAN_HEIGHT = 256;
  localparam int MAX_OFFSET = 3145727;

  localparam int ANGLE_W  = 9;
  localparam int RADIUS_W = 8;
  localparam int OFFSET_W = 22;
  localparam int WIDTH_W  = 11;
  localparam int CENTER_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd3;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [WIDTH_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 10'd320;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 10'd240;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle_deg;
    logic [RADIUS_W-1:0] radius;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic                out_of_range;
  } out_t;

  // folded table index and sign of a quadrant
  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } trig_idx_t;

  typedef logic [0:127][16:0] sin_tab_t;

  // ---- table generator, evaluated at elaboration only ----
  localparam logic [63:0] Q60_PI   = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q60_STEP = Q60_PI / 64'd180;

  localparam logic [63:0] TAYLOR_DIV [1:13] = '{
    64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
    64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
  };

  // (a*b) >> 60 for Q4.60 operands below 2^62
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ah * bh * 64'd16 + (mid >> 28);
  endfunction

  function automatic logic [16:0] quarter_sin(input int unsigned d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    x    = Q60_STEP * 64'(d);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 13; k++) begin
      term = mul_q60(term, x2) / TAYLOR_DIV[k];
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    rnd = (sum + (64'd1 << 43)) >> 44;
    return rnd[16:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    for (int d = 0; d < 128; d++) begin
      t[d] = (d <= 90) ? quarter_sin(d) : 17'd0;
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // fold an angle in degrees onto the first quadrant
  function automatic trig_idx_t fold_angle(input logic [ANGLE_W-1:0] a);
    trig_idx_t   t;
    logic [ANGLE_W-1:0] v;
    t.neg = 1'b0;
    if (a <= 9'd90) begin
      v = a;
    end else if (a <= 9'd180) begin
      v = 9'd180 - a;
    end else if (a <= 9'd270) begin
      v = a - 9'd180;
      t.neg = 1'b1;
    end else begin
      v = 9'd360 - a;
      t.neg = 1'b1;
    end
    t.idx = v[6:0];
    return t;
  endfunction

  function automatic logic signed [17:0] trig_value(input trig_idx_t t);
    logic signed [17:0] v;
    v = signed'({1'b0, SIN_TAB[t.idx]});
    return t.neg ? -v : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/polar_unwarp_address_generator_top.sv */
// Throughput: one request per cycle while the output is not stalled; four
// register stages (trig lookup, multiply by radius, bounds check with row
// multiply, offset sum) each with its own valid bit, so a stalled output
// holds only the stages behind it.
// Reset: synchronous active-low; clears all valid bits and restores the
// image geometry registers to 640x480 with center 320,240.
// ----------------------------------------------------------------------------
// polar_unwarp_address_generator_top - panorama coordinate to RGB byte offset
// Maps (angle, radius) to x = cx + floor(r*cos), y = cy + floor(r*sin) and
// the byte offset (x + y*width)*3, flagging points outside the image.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_unwarp_address_generator_top
  import pua_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // geometry registers
  logic [WIDTH_W-1:0]  width_r;
  logic [WIDTH_W-1:0]  height_r;
  logic [CENTER_W-1:0] cx_r;
  logic [CENTER_W-1:0] cy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      cx_r     <= RST_CENTER_X;
      cy_r     <= RST_CENTER_Y;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_CENTER_X:     cx_r     <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y:     cy_r     <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // ---- stage 1: trig lookup ----
  logic [ANGLE_W:0]   cos_ang;
  logic [ANGLE_W-1:0] cos_fold;
  logic               bad_in;

  always_comb begin
    cos_ang  = {1'b0, in_data.angle_deg} + 10'd90;
    if (cos_ang >= 10'(PAN_WIDTH)) cos_ang = cos_ang - 10'(PAN_WIDTH);
    cos_fold = cos_ang[ANGLE_W-1:0];
    bad_in   = ({1'b0, in_data.angle_deg} >= 10'(PAN_WIDTH)) ||
               ({2'b0, in_data.radius} >= 10'(PAN_HEIGHT));
  end

  logic signed [17:0]  sin1_r, cos1_r;
  logic [RADIUS_W-1:0] rad1_r;
  logic                bad1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (rdy1) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sin1_r <= trig_value(fold_angle(in_data.angle_deg));
      cos1_r <= trig_value(fold_angle(cos_fold));
      rad1_r <= in_data.radius;
      bad1_r <= bad_in;
    end
  end

  // ---- stage 2: scale by radius, floor, add center ----
  logic signed [26:0] px, py;
  logic signed [11:0] x2_nxt, y2_nxt;

  always_comb begin
    px     = 27'(signed'({1'b0, rad1_r})) * 27'(cos1_r);
    py     = 27'(signed'({1'b0, rad1_r})) * 27'(sin1_r);
    // arithmetic shift floors toward minus infinity
    x2_nxt = signed'({2'b0, cx_r}) + 12'(px >>> 16);
    y2_nxt = signed'({2'b0, cy_r}) + 12'(py >>> 16);
  end

  logic signed [11:0] x2_r, y2_r;
  logic               bad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (rdy2) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      bad2_r <= bad1_r;
    end
  end

  // ---- stage 3: bounds check and row multiply ----
  logic                bad3_nxt;
  logic [OFFSET_W-1:0] row3_nxt;

  always_comb begin
    bad3_nxt = bad2_r || x2_r[11] || y2_r[11] ||
               (x2_r[10:0] >= width_r) || (y2_r[10:0] >= height_r);
    row3_nxt = {11'b0, y2_r[10:0]} * {11'b0, width_r};
  end

  logic [WIDTH_W-1:0]  x3_r;
  logic [OFFSET_W-1:0] row3_r;
  logic                bad3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (rdy3) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x3_r   <= x2_r[10:0];
      row3_r <= row3_nxt;
      bad3_r <= bad3_nxt;
    end
  end

  // ---- stage 4: offset = (x + y*w)*3, output register ----
  logic [23:0] pix_sum;
  logic [25:0] off_full;
  logic        bad4;

  always_comb begin
    pix_sum  = {2'b0, row3_r} + {13'b0, x3_r};
    off_full = {2'b0, pix_sum} + {1'b0, pix_sum, 1'b0};
    bad4     = bad3_r || (off_full > 26'(MAX_OFFSET));
  end

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (rdy4) out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      out_data_r.byte_offset  <= bad4 ? '0 : off_full[OFFSET_W-1:0];
      out_data_r.out_of_range <= bad4;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.out_of_range || out_data.byte_offset == '0))
    else $error("out_of_range result carries a nonzero offset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && v1_r && v2_r && v3_r))
    else $error("input stalled while the pipeline has room");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && rdy4) |=> out_valid)
    else $error("stage 3 request lost on its way to the output");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_offset <= OFFSET_W'(MAX_OFFSET)))
    else $error("byte offset above the buffer size");

endmodule

`default_nettype wire
